FILE: sv/glce_pkg.sv
// Shared types and constants for the grouped logit classify and error unit.
// Used by the top level; depends on nothing.
`default_nettype none

package glce_pkg;

    // Command codes carried on s_tuser
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_ELEM   = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    // Result kinds carried on m_tuser
    localparam logic KIND_ROW    = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam int COEF_BITS  = 16;
    localparam int PROD_BITS  = 32;
    localparam int ACC_BITS   = 40;
    localparam int DIFF_BITS  = 16;
    localparam int SQ_BITS    = 32;
    localparam int ERR_BITS   = 31;
    localparam int TOTAL_BITS = 48;
    localparam int CNTO_BITS  = 20;
    localparam int DIVC_BITS  = 6;

    localparam logic [ERR_BITS-1:0]   ROW_ERR_MAX = 31'd1090519040;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX   = {TOTAL_BITS{1'b1}};
    localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
    localparam logic signed [DIFF_BITS:0]  ONE_Q8  = 17'sd256;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_SQUARE,
        ST_ACCUM,
        ST_DIVIDE,
        ST_REPORT
    } state_t;

    // Control bits that travel with an element or finish request down the pipe
    typedef struct packed {
        logic fin;
        logic last;
        logic in_range;
    } pipe_ctl_t;

endpackage

`default_nettype wire

FILE: sv/glce_ram.sv
// Generic single-clock RAM, one write port and one read port, registered read.
// No dependencies.
`default_nettype none

module glce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire                                     clk,
    input  wire                                     we,
    input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire [WIDTH-1:0]                         wdata,
    input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: sv/grouped_logit_classify_error_unit.sv
// Grouped logit classifier with squared-error scoring.
// Requests arrive on the s_ stream, results leave on the m_ stream.
// s_tuser carries the command: load a coefficient, a feature element, or finish.
// A load writes the coefficient RAM at once; the next request may read it.
// Feature elements are taken one per cycle while s_tready is high; each reads
// its coefficient from the RAM, is multiplied and is accumulated, each step
// registered. An element marked by s_tlast closes the row: input stops until
// the row result is in the output register, and the next request is taken
// after that. The score test, the squaring and the total update are done in
// turn by a small sequencer; the total update waits for a free output register.
// A finish request runs a restoring divider, one quotient bit a cycle over the
// 48-bit total, and reports when the output register is free, then clears the
// total and the row count.
// When the receiver stalls, the finished result holds in the output register;
// a new row end or finish waits in the sequencer until the register is taken;
// no new request is taken meanwhile. Reset clears the score, total, count and
// pipeline; the coefficient RAM is not cleared and must be loaded before use.
// Depends on glce_pkg and glce_ram.
`default_nettype none

module grouped_logit_classify_error_unit #(
    parameter int NUM_GROUPS   = 16,
    parameter int NUM_FEATURES = 8,
    parameter int COUNT_BITS   = 20
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [39:0]  s_tdata,  // group[3:0], feature_index[6:4], value[22:7],
                                   // label[38:23], zero[39]
    input  wire  [1:0]   s_tuser,  // command[1:0]
    input  wire          s_tlast,  // last_of_row
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [135:0] m_tdata,  // predicted[0], row_error[31:1],
                                   // total_error[79:32], row_count[99:80],
                                   // mean_error[130:100], zero[135:131]
    output logic         m_tuser   // kind
);

    import glce_pkg::*;

    localparam int DEPTH  = NUM_GROUPS * NUM_FEATURES;
    localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Request fields
    logic [3:0]                  in_group;
    logic [2:0]                  in_feat;
    logic signed [COEF_BITS-1:0] in_value;
    logic signed [COEF_BITS-1:0] in_label;
    logic [1:0]                  in_cmd;
    logic                        accept;
    logic                        in_range;
    logic [ADDR_W-1:0]           slot;
    logic [COEF_BITS-1:0]        coef_rd;

    assign in_group = s_tdata[3:0];
    assign in_feat  = s_tdata[6:4];
    assign in_value = s_tdata[22:7];
    assign in_label = s_tdata[38:23];
    assign in_cmd   = s_tuser;
    assign accept   = s_tvalid && s_tready;
    assign in_range = (32'(in_group) < NUM_GROUPS) && (32'(in_feat) < NUM_FEATURES);
    assign slot     = in_range
                    ? ADDR_W'(32'(in_group) * 32'(NUM_FEATURES) + 32'(in_feat))
                    : '0;

    glce_ram #(
        .WIDTH (COEF_BITS),
        .DEPTH (DEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (accept && (in_cmd == CMD_LOAD) && in_range),
        .waddr (slot),
        .wdata (in_value),
        .raddr (slot),
        .rdata (coef_rd)
    );

    // Pipeline and sequencer registers
    state_t                       state_reg, state_next;
    logic                         v1_reg, v2_reg;
    pipe_ctl_t                    ctl1_reg, ctl2_reg;
    logic signed [COEF_BITS-1:0]  val1_reg;
    logic signed [COEF_BITS-1:0]  lab1_reg, lab2_reg;
    logic signed [PROD_BITS-1:0]  prod2_reg;
    logic signed [ACC_BITS-1:0]   acc_reg, acc_next;
    logic                         pred_reg, pred_next;
    logic [DIFF_BITS-1:0]         adiff_reg, adiff_next;
    logic [ERR_BITS-1:0]          sq_reg, sq_next;
    logic [TOTAL_BITS-1:0]        total_reg, total_next;
    logic [COUNT_BITS-1:0]        rows_reg, rows_next;
    logic [COUNT_BITS-1:0]        rem_reg, rem_next;
    logic [TOTAL_BITS-1:0]        dvd_reg, dvd_next;
    logic [DIVC_BITS-1:0]         divc_reg, divc_next;

    // Output register
    logic                         m_valid_reg, m_valid_next;
    logic                         o_kind_reg, o_kind_next;
    logic                         o_pred_reg, o_pred_next;
    logic [ERR_BITS-1:0]          o_rerr_reg, o_rerr_next;
    logic [TOTAL_BITS-1:0]        o_total_reg, o_total_next;
    logic [CNTO_BITS-1:0]         o_count_reg, o_count_next;
    logic [ERR_BITS-1:0]          o_mean_reg, o_mean_next;

    // Combinational helpers
    logic                         out_free;
    logic                         end1, end2;
    logic signed [ACC_BITS:0]     acc_sum;
    logic signed [ACC_BITS-1:0]   acc_upd;
    logic signed [DIFF_BITS:0]    diff;
    logic [DIFF_BITS:0]           diff_mag;
    logic [SQ_BITS-1:0]           sq_full;
    logic [TOTAL_BITS:0]          total_sum;
    logic [COUNT_BITS:0]          rem_shift;
    logic                         qbit;

    assign out_free = !m_valid_reg || m_tready;
    assign end1     = ctl1_reg.fin || ctl1_reg.last;
    assign end2     = ctl2_reg.fin || ctl2_reg.last;
    // Block new requests while the sequencer is busy or a row end or finish is still in flight
    assign s_tready = (state_reg == ST_RUN) && !(v1_reg && end1) && !(v2_reg && end2);

    assign acc_sum = {acc_reg[ACC_BITS-1], acc_reg}
                   + ((ctl2_reg.in_range && !ctl2_reg.fin) ? (ACC_BITS+1)'(prod2_reg) : '0);

    always_comb
    begin
        if (acc_sum[ACC_BITS] != acc_sum[ACC_BITS-1])
        begin
            acc_upd = acc_sum[ACC_BITS] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            acc_upd = acc_sum[ACC_BITS-1:0];
        end
    end

    assign diff      = (DIFF_BITS+1)'(lab2_reg) - ((acc_upd > 0) ? ONE_Q8 : 17'sd0);
    assign diff_mag  = diff[DIFF_BITS] ? (DIFF_BITS+1)'(-diff) : (DIFF_BITS+1)'(diff);
    assign sq_full   = SQ_BITS'(adiff_reg) * SQ_BITS'(adiff_reg);
    assign total_sum = {1'b0, total_reg} + (TOTAL_BITS+1)'(sq_reg);
    assign rem_shift = {rem_reg, dvd_reg[TOTAL_BITS-1]};
    assign qbit      = rem_shift >= {1'b0, rows_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_RUN;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            acc_reg     <= '0;
            total_reg   <= '0;
            rows_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            v1_reg      <= accept && ((in_cmd == CMD_ELEM) || (in_cmd == CMD_FINISH));
            v2_reg      <= v1_reg;
            acc_reg     <= acc_next;
            total_reg   <= total_next;
            rows_reg    <= rows_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ctl1_reg    <= '{fin: (in_cmd == CMD_FINISH), last: s_tlast, in_range: in_range};
        val1_reg    <= in_value;
        lab1_reg    <= in_label;
        ctl2_reg    <= ctl1_reg;
        lab2_reg    <= lab1_reg;
        prod2_reg   <= PROD_BITS'(val1_reg) * PROD_BITS'($signed(coef_rd));
        pred_reg    <= pred_next;
        adiff_reg   <= adiff_next;
        sq_reg      <= sq_next;
        rem_reg     <= rem_next;
        dvd_reg     <= dvd_next;
        divc_reg    <= divc_next;
        o_kind_reg  <= o_kind_next;
        o_pred_reg  <= o_pred_next;
        o_rerr_reg  <= o_rerr_next;
        o_total_reg <= o_total_next;
        o_count_reg <= o_count_next;
        o_mean_reg  <= o_mean_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        acc_next     = acc_reg;
        total_next   = total_reg;
        rows_next    = rows_reg;
        pred_next    = pred_reg;
        adiff_next   = adiff_reg;
        sq_next      = sq_reg;
        rem_next     = rem_reg;
        dvd_next     = dvd_reg;
        divc_next    = divc_reg;
        m_valid_next = m_valid_reg && !m_tready;
        o_kind_next  = o_kind_reg;
        o_pred_next  = o_pred_reg;
        o_rerr_next  = o_rerr_reg;
        o_total_next = o_total_reg;
        o_count_next = o_count_reg;
        o_mean_next  = o_mean_reg;

        case (state_reg)
            ST_RUN:
            begin
                if (v2_reg)
                begin
                    if (ctl2_reg.fin)
                    begin
                        rem_next   = '0;
                        dvd_next   = total_reg;
                        divc_next  = '0;
                        state_next = ST_DIVIDE;
                    end
                    else if (ctl2_reg.last)
                    begin
                        // Classify on the updated score, then restart it
                        pred_next  = acc_upd > 0;
                        adiff_next = diff_mag[DIFF_BITS-1:0];
                        acc_next   = '0;
                        state_next = ST_SQUARE;
                    end
                    else
                    begin
                        acc_next = acc_upd;
                    end
                end
            end

            ST_SQUARE:
            begin
                sq_next    = (sq_full > SQ_BITS'(ROW_ERR_MAX)) ? ROW_ERR_MAX
                                                               : sq_full[ERR_BITS-1:0];
                state_next = ST_ACCUM;
            end

            ST_ACCUM:
            begin
                if (out_free)
                begin
                    total_next   = total_sum[TOTAL_BITS] ? TOTAL_MAX
                                                         : total_sum[TOTAL_BITS-1:0];
                    rows_next    = (rows_reg == COUNT_MAX) ? rows_reg
                                                           : rows_reg + COUNT_BITS'(1);
                    m_valid_next = 1'b1;
                    o_kind_next  = KIND_ROW;
                    o_pred_next  = pred_reg;
                    o_rerr_next  = sq_reg;
                    o_total_next = total_next;
                    o_count_next = CNTO_BITS'(rows_next);
                    o_mean_next  = '0;
                    state_next   = ST_RUN;
                end
            end

            ST_DIVIDE:
            begin
                // Restoring division, one quotient bit per cycle
                rem_next  = qbit ? COUNT_BITS'(rem_shift - {1'b0, rows_reg})
                                 : rem_shift[COUNT_BITS-1:0];
                dvd_next  = {dvd_reg[TOTAL_BITS-2:0], qbit};
                divc_next = divc_reg + DIVC_BITS'(1);
                if (divc_reg == DIVC_BITS'(TOTAL_BITS - 1))
                begin
                    state_next = ST_REPORT;
                end
            end

            ST_REPORT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    o_kind_next  = KIND_REPORT;
                    o_pred_next  = 1'b0;
                    o_rerr_next  = '0;
                    o_total_next = total_reg;
                    o_count_next = CNTO_BITS'(rows_reg);
                    if (rows_reg == '0)
                    begin
                        o_mean_next = '0;
                    end
                    else if (dvd_reg > TOTAL_BITS'(ROW_ERR_MAX))
                    begin
                        o_mean_next = ROW_ERR_MAX;
                    end
                    else
                    begin
                        o_mean_next = dvd_reg[ERR_BITS-1:0];
                    end
                    total_next = '0;
                    rows_next  = '0;
                    state_next = ST_RUN;
                end
            end

            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = o_kind_reg;
    assign m_tdata  = {5'b0, o_mean_reg, o_count_reg, o_total_reg, o_rerr_reg, o_pred_reg};

endmodule

`default_nettype wire
